[rtl/core/tlb_page_table_translator_assert.svh]
// Assertion macros for the TLB and page-table translator.
// Included by the top level; no dependencies. Define NO_ASSERTIONS to drop them.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property at every clock edge outside reset
`define TLBPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define TLBPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TLBPT_ASSERT(lbl, prop, msg)
`define TLBPT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/tlbpt_pkg.sv]
// Shared types and constants for the TLB and page-table translator.
// No dependencies; used by the interfaces and the top level.
package tlbpt_pkg;

  localparam int unsigned VA_W     = 16;
  localparam int unsigned PAGE_W   = 8;
  localparam int unsigned OFFSET_W = 8;
  localparam int unsigned FRAME_W  = 8;
  localparam int unsigned CNT_W    = 32;

  localparam int unsigned TLB_ENTRIES_DEF = 16;
  localparam int unsigned PAGE_COUNT_DEF  = 256;

  // One TLB entry: tag page and its frame
  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlbpt_entry_t;

  localparam int unsigned ENTRY_W = $bits(tlbpt_entry_t);

  // Translation sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_MISS,
    ST_SHIFT,
    ST_DONE
  } tlbpt_state_e;

endpackage

[rtl/core/tlbpt_va_if.sv]
// Request channel carrying one virtual address.
// Depends on tlbpt_pkg for the field width.
interface tlbpt_va_if
  import tlbpt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [VA_W-1:0]   virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

[rtl/core/tlbpt_pa_if.sv]
// Result channel carrying the translated address, flags and totals.
// Depends on tlbpt_pkg for the field widths.
interface tlbpt_pa_if
  import tlbpt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [VA_W-1:0]   physical_address;
  logic              tlb_hit;
  logic              page_fault;
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  fault_total;

  modport source (output valid, output physical_address, output tlb_hit,
                  output page_fault, output hit_total, output fault_total,
                  input ready);
  modport sink   (input valid, input physical_address, input tlb_hit,
                  input page_fault, input hit_total, input fault_total,
                  output ready);
endinterface

[rtl/core/tlbpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the TLB entries and the page-to-frame table.
module tlbpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/tlb_page_table_translator.sv]
// TLB and page-table translator. One request takes a 16-bit virtual address and
// returns its physical address, TLB-hit and page-fault flags and the running hit
// and fault totals. The block handles one request at a time. From acceptance to
// result it folds the page number into range by subtracting PAGE_COUNT, compares
// the TLB entries oldest first until a match or the end of the valid entries,
// looks the page up in the page table on a miss, after a hit or a miss with a full
// TLB closes up the LRU order one entry a cycle, and loads the result
// register, held back while an earlier result still waits to be taken. The
// search and the LRU shift both go through the single read port of the TLB RAM,
// one entry a cycle. A result waiting in the output register does not stop the
// next request being taken. No clearing pass is needed after reset: page-mapped
// flags live in flip-flops and the TLB is guarded by its fill count.
`include "tlb_page_table_translator_assert.svh"

module tlb_page_table_translator
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_COUNT  = PAGE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlbpt_va_if.sink    va_i,
  tlbpt_pa_if.source  pa_o
);

  localparam int unsigned AW  = $clog2(TLB_ENTRIES);
  localparam int unsigned FW  = $clog2(TLB_ENTRIES + 1);
  localparam int unsigned PAW = $clog2(PAGE_COUNT);
  localparam int unsigned NW  = $clog2(PAGE_COUNT + 1);

  tlbpt_state_e state_q, state_d;

  logic [PAGE_W-1:0]   page_q, page_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic                hit_q, hit_d;
  logic                fault_q, fault_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic [NW-1:0]       nff_q, nff_d;
  logic [CNT_W-1:0]    hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]    fault_cnt_q, fault_cnt_d;
  logic [PAGE_COUNT-1:0] mapped_q, mapped_d;

  logic                ov_q;
  logic [VA_W-1:0]     opa_q;
  logic                ohit_q, ofault_q;
  logic [CNT_W-1:0]    ohtot_q, oftot_q;

  tlbpt_entry_t        tlb_rd, tlb_wdata;
  logic                tlb_we;
  logic [AW-1:0]       tlb_waddr, tlb_raddr;
  logic [ENTRY_W-1:0]  tlb_rd_raw;
  logic [FRAME_W-1:0]  pt_rd;
  logic                pt_we;
  logic [FRAME_W-1:0]  new_frame;

  logic                accept;
  logic                out_free;
  logic                page_big;
  logic                match;
  logic                map_hit;
  logic                tlb_full;
  logic [AW-1:0]       last_idx;
  logic [AW-1:0]       idx_inc1, idx_inc2;

  assign accept   = va_i.valid && va_i.ready;
  assign out_free = !ov_q || pa_o.ready;
  assign page_big = {1'b0, page_q} >= (PAGE_W + 1)'(PAGE_COUNT);
  assign tlb_rd   = tlbpt_entry_t'(tlb_rd_raw);
  assign match    = (tlb_rd.page == page_q);
  assign map_hit  = mapped_q[page_q[PAW-1:0]];
  assign tlb_full = (fill_q >= FW'(TLB_ENTRIES));
  assign last_idx = AW'(fill_q - FW'(1));
  assign idx_inc1 = AW'({1'b0, idx_q} + (AW + 1)'(1));
  assign idx_inc2 = AW'({1'b0, idx_q} + (AW + 1)'(2));
  assign new_frame = map_hit ? pt_rd : FRAME_W'(nff_q);

  assign va_i.ready = (state_q == ST_IDLE);

  // TLB entries, kept oldest first
  tlbpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TLB_ENTRIES)
  ) u_tlb_ram (
    .clk_i   (clk_i),
    .we_i    (tlb_we),
    .waddr_i (tlb_waddr),
    .wdata_i (tlb_wdata),
    .raddr_i (tlb_raddr),
    .rdata_o (tlb_rd_raw)
  );

  // Page-to-frame table, its read data used only where the mapped flag is set
  tlbpt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (PAGE_COUNT)
  ) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (page_q[PAW-1:0]),
    .wdata_i (new_frame),
    .raddr_i (page_d[PAW-1:0]),
    .rdata_o (pt_rd)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (va_i.valid) state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (!page_big) state_d = (fill_q == '0) ? ST_MISS : ST_SCAN;
      end
      ST_SCAN: begin
        if (match) state_d = ST_SHIFT;
        else if (idx_q == last_idx) state_d = ST_MISS;
      end
      ST_MISS: begin
        state_d = tlb_full ? ST_SHIFT : ST_DONE;
      end
      ST_SHIFT: begin
        if (idx_q == last_idx) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control per state
  always_comb begin
    page_d      = page_q;
    offset_d    = offset_q;
    frame_d     = frame_q;
    hit_d       = hit_q;
    fault_d     = fault_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    nff_d       = nff_q;
    hit_cnt_d   = hit_cnt_q;
    fault_cnt_d = fault_cnt_q;
    mapped_d    = mapped_q;
    tlb_we      = 1'b0;
    tlb_waddr   = idx_q;
    tlb_wdata   = tlb_rd;
    tlb_raddr   = '0;
    pt_we       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // latch the request
        if (accept) begin
          page_d   = va_i.virtual_address[VA_W-1 -: PAGE_W];
          offset_d = va_i.virtual_address[OFFSET_W-1:0];
          hit_d    = 1'b0;
          fault_d  = 1'b0;
        end
      end
      ST_REDUCE: begin
        // fold the page into range, then start the TLB read at the oldest entry
        if (page_big) page_d = page_q - PAGE_W'(PAGE_COUNT);
        idx_d = '0;
      end
      ST_SCAN: begin
        // compare one entry, prefetch the next
        tlb_raddr = idx_inc1;
        if (match) begin
          hit_d     = 1'b1;
          frame_d   = tlb_rd.frame;
          hit_cnt_d = hit_cnt_q + CNT_W'(1);
        end else begin
          idx_d = idx_inc1;
        end
      end
      ST_MISS: begin
        // page table lookup; on a fault hand out the next free frame
        frame_d = new_frame;
        if (!map_hit) begin
          pt_we       = 1'b1;
          mapped_d[page_q[PAW-1:0]] = 1'b1;
          fault_d     = 1'b1;
          fault_cnt_d = fault_cnt_q + CNT_W'(1);
          if (nff_q < NW'(PAGE_COUNT)) nff_d = nff_q + NW'(1);
        end
        if (!tlb_full) begin
          tlb_we    = 1'b1;
          tlb_waddr = AW'(fill_q);
          tlb_wdata = '{page: page_q, frame: new_frame};
          fill_d    = fill_q + FW'(1);
        end else begin
          // evict the oldest: shift from slot zero, entry one already in flight
          idx_d     = '0;
          tlb_raddr = AW'(1);
        end
      end
      ST_SHIFT: begin
        // close the gap one entry a cycle, then put the request at the recent end
        tlb_we = 1'b1;
        if (idx_q == last_idx) begin
          tlb_wdata = '{page: page_q, frame: frame_q};
        end else begin
          tlb_wdata = tlb_rd;
          tlb_raddr = idx_inc2;
          idx_d     = idx_inc1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      nff_q       <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      mapped_q    <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      nff_q       <= nff_d;
      hit_cnt_q   <= hit_cnt_d;
      fault_cnt_q <= fault_cnt_d;
      mapped_q    <= mapped_d;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk_i) begin
    page_q   <= page_d;
    offset_q <= offset_d;
    frame_q  <= frame_d;
    hit_q    <= hit_d;
    fault_q  <= fault_d;
    idx_q    <= idx_d;
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      ov_q <= 1'b1;
    end else if (pa_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      opa_q    <= {frame_q, offset_q};
      ohit_q   <= hit_q;
      ofault_q <= fault_q;
      ohtot_q  <= hit_cnt_q;
      oftot_q  <= fault_cnt_q;
    end
  end

  assign pa_o.valid            = ov_q;
  assign pa_o.physical_address = opa_q;
  assign pa_o.tlb_hit          = ohit_q;
  assign pa_o.page_fault       = ofault_q;
  assign pa_o.hit_total        = ohtot_q;
  assign pa_o.fault_total      = oftot_q;

  `TLBPT_ASSERT(a_fill_bound, fill_q <= FW'(TLB_ENTRIES), "TLB fill count beyond its depth")

  `TLBPT_ASSERT(a_flags_excl, !(pa_o.valid && pa_o.tlb_hit && pa_o.page_fault),
                "hit and fault together")

  `TLBPT_ASSERT_NEXT(a_fill_step, state_q != ST_MISS, fill_q == $past(fill_q),
                     "fill moved outside a miss")

  `TLBPT_ASSERT_NEXT(a_fault_cnt, state_q == ST_MISS && !map_hit,
                     fault_cnt_q == $past(fault_cnt_q) + CNT_W'(1), "fault not counted")

endmodule
